[hw/rtl/umpds_pkg.sv]
// ----------------------------------------------------------------------------
// umpds_pkg
// Types, codes and helpers for the MIDI 2.0 to MIDI 1.0 UMP downscaler.
// ----------------------------------------------------------------------------
package umpds_pkg;

  // message types, first word bits 31:28
  localparam logic [3:0] MT_CV1 = 4'h2;
  localparam logic [3:0] MT_CV2 = 4'h4;

  // channel voice status codes
  localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
  localparam logic [3:0] ST_NOTE_ON    = 4'h9;
  localparam logic [3:0] ST_POLY_PRESS = 4'hA;
  localparam logic [3:0] ST_CTRL       = 4'hB;
  localparam logic [3:0] ST_PROGRAM    = 4'hC;
  localparam logic [3:0] ST_CHAN_PRESS = 4'hD;
  localparam logic [3:0] ST_BEND       = 4'hE;

  // bank select controller numbers
  localparam logic [6:0] CC_BANK_MSB = 7'd0;
  localparam logic [6:0] CC_BANK_LSB = 7'd32;

  localparam logic [2:0] NW_MIN = 3'd1;
  localparam logic [2:0] NW_MAX = 3'd4;

  // results per packet, and the index that walks them
  localparam int SLOTS = 3;
  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] IDX_ONE   = 2'd0;
  localparam logic [IDX_W-1:0] IDX_THREE = 2'd2;

  localparam int TS_W = 63;

  typedef struct packed {
    logic [31:0]     in_word0;
    logic [31:0]     in_word1;
    logic [31:0]     in_word2;
    logic [31:0]     in_word3;
    logic [2:0]      in_num_words;
    logic [TS_W-1:0] in_timestamp;
  } in_pkt_t;

  typedef struct packed {
    logic [31:0]     out_word0;
    logic [31:0]     out_word1;
    logic [31:0]     out_word2;
    logic [31:0]     out_word3;
    logic [2:0]      out_num_words;
    logic [TS_W-1:0] out_timestamp;
    logic            last;
  } out_pkt_t;

  // translated packet: one to three results sharing the trailing words
  typedef struct packed {
    logic [SLOTS-1:0][31:0]     word0;
    logic [SLOTS-1:0][TS_W-1:0] ts;
    logic [31:0]                word1;
    logic [31:0]                word2;
    logic [31:0]                word3;
    logic [2:0]                 num_words;
    logic [IDX_W-1:0]           last_idx;
  } xp_t;

  function automatic logic [31:0] midi1_msg(input logic [3:0] group,
                                            input logic [3:0] opcode,
                                            input logic [3:0] chan,
                                            input logic [6:0] d1,
                                            input logic [6:0] d2);
    midi1_msg = {MT_CV1, group, opcode, chan, 1'b0, d1, 1'b0, d2};
  endfunction

endpackage

[hw/rtl/umpds_expand.sv]
// ----------------------------------------------------------------------------
// umpds_expand
// Holds one translated packet and issues its results, one per cycle while the
// output register is empty or being read, into the output register.
// ----------------------------------------------------------------------------
module umpds_expand
  import umpds_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     xp_valid,
  output logic     xp_ready,
  input  xp_t      xp,
  output logic     out_valid,
  input  logic     out_ready,
  output out_pkt_t out_data
);

  logic             buf_valid;
  xp_t              buf_xp;
  logic [IDX_W-1:0] idx;
  logic             issue;
  logic             at_last;

  assign issue    = buf_valid && (!out_valid || out_ready);
  assign at_last  = (idx == buf_xp.last_idx);
  assign xp_ready = !buf_valid || (issue && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      idx       <= IDX_ONE;
      out_valid <= 1'b0;
    end else begin
      if (xp_ready) begin
        buf_valid <= xp_valid;
        idx       <= IDX_ONE;
      end else if (issue) begin
        idx <= idx + 1'b1;
      end
      if (issue) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xp_ready && xp_valid) begin
      buf_xp <= xp;
    end
    if (issue) begin
      out_data.out_word0     <= buf_xp.word0[idx];
      out_data.out_word1     <= buf_xp.word1;
      out_data.out_word2     <= buf_xp.word2;
      out_data.out_word3     <= buf_xp.word3;
      out_data.out_num_words <= buf_xp.num_words;
      out_data.out_timestamp <= buf_xp.ts[idx];
      out_data.last          <= at_last;
    end
  end

endmodule

[hw/rtl/ump_midi2_to_midi1_downscaler.sv]
// ----------------------------------------------------------------------------
// ump_midi2_to_midi1_downscaler
// Turns MIDI 2.0 channel voice packets of status 8 to E into MIDI 1.0 channel
// voice packets; every other packet passes through with its length clamped to 1..4.
// ----------------------------------------------------------------------------
// Path: stage 1 register, stage 2 register, expander buffer, output register.
// Throughput: one packet per cycle while the output is not stalled; a program
// change with the bank-valid bit yields three results, issued one per cycle.
// Reset: synchronous; empties every stage, no packet is in flight after it.
module ump_midi2_to_midi1_downscaler
  import umpds_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_pkt_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_pkt_t out_data
);

  logic    s1_valid;
  in_pkt_t s1_pkt;
  logic    s2_valid;
  logic    s2_ready;
  xp_t     s2_xp;
  xp_t     s2_xp_next;
  logic    x_ready;
  logic [2:0] nw_clamped;

  assign s2_ready = !s2_valid || x_ready;
  assign in_ready = !s1_valid || s2_ready;

  always_comb begin
    if (in_data.in_num_words == 3'd0) begin
      nw_clamped = NW_MIN;
    end else if (in_data.in_num_words > NW_MAX) begin
      nw_clamped = NW_MAX;
    end else begin
      nw_clamped = in_data.in_num_words;
    end
  end

  // stage 1: capture the packet, length clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_pkt <= '{in_data.in_word0, in_data.in_word1, in_data.in_word2,
                  in_data.in_word3, nw_clamped, in_data.in_timestamp};
    end
  end

  // stage 2: translate
  always_comb begin
    logic [31:0] w0;
    logic [31:0] w1;
    logic [3:0]  group;
    logic [3:0]  status;
    logic [3:0]  chan;
    logic [6:0]  note;
    logic        convert;
    w0      = s1_pkt.in_word0;
    w1      = s1_pkt.in_word1;
    group   = w0[27:24];
    status  = w0[23:20];
    chan    = w0[19:16];
    note    = w0[14:8];
    convert = 1'b1;

    s2_xp_next.word0    = '0;
    s2_xp_next.ts[0]    = s1_pkt.in_timestamp;
    s2_xp_next.ts[1]    = s1_pkt.in_timestamp + TS_W'(1);
    s2_xp_next.ts[2]    = s1_pkt.in_timestamp + TS_W'(2);
    s2_xp_next.last_idx = IDX_ONE;

    unique case (status)
      ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRESS, ST_CTRL: begin
        s2_xp_next.word0[0] = midi1_msg(group, status, chan, note, w1[31:25]);
      end
      ST_CHAN_PRESS: begin
        s2_xp_next.word0[0] = midi1_msg(group, ST_CHAN_PRESS, chan, w1[31:25], 7'd0);
      end
      ST_BEND: begin
        s2_xp_next.word0[0] = midi1_msg(group, ST_BEND, chan, w1[24:18], w1[31:25]);
      end
      ST_PROGRAM: begin
        if (w0[0]) begin
          s2_xp_next.word0[0] = midi1_msg(group, ST_CTRL, chan, CC_BANK_MSB, w1[14:8]);
          s2_xp_next.word0[1] = midi1_msg(group, ST_CTRL, chan, CC_BANK_LSB, w1[6:0]);
          s2_xp_next.word0[2] = midi1_msg(group, ST_PROGRAM, chan, w1[30:24], 7'd0);
          s2_xp_next.last_idx = IDX_THREE;
        end else begin
          // program change alone still goes out at the third offset
          s2_xp_next.word0[0] = midi1_msg(group, ST_PROGRAM, chan, w1[30:24], 7'd0);
          s2_xp_next.ts[0]    = s1_pkt.in_timestamp + TS_W'(2);
        end
      end
      default: begin
        convert = 1'b0;
      end
    endcase

    if (convert && (w0[31:28] == MT_CV2)) begin
      s2_xp_next.word1     = '0;
      s2_xp_next.word2     = '0;
      s2_xp_next.word3     = '0;
      s2_xp_next.num_words = NW_MIN;
    end else begin
      s2_xp_next.word0[0]  = w0;
      s2_xp_next.ts[0]     = s1_pkt.in_timestamp;
      s2_xp_next.last_idx  = IDX_ONE;
      s2_xp_next.word1     = w1;
      s2_xp_next.word2     = s1_pkt.in_word2;
      s2_xp_next.word3     = s1_pkt.in_word3;
      s2_xp_next.num_words = s1_pkt.in_num_words;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_xp <= s2_xp_next;
    end
  end

  // stages 3 and 4: hold the packet and issue its results
  umpds_expand u_expand (
    .clk       (clk),
    .rst       (rst),
    .xp_valid  (s2_valid),
    .xp_ready  (x_ready),
    .xp        (s2_xp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[tb/sv/umpds_scoreboard_pkg.sv]
// ----------------------------------------------------------------------------
// umpds_scoreboard_pkg
// Result predictor and in-order checker for the MIDI 2.0 to MIDI 1.0 UMP
// downscaler: each accepted packet is translated into the MIDI 1.0 packets
// it should produce, and each result leaving the block is matched against
// the oldest one still due.
// ----------------------------------------------------------------------------
package umpds_scoreboard_pkg;
  import umpds_pkg::*;

  class midi1_scoreboard;
    out_pkt_t midi1_due[$];
    int mismatches;
    int results_checked;
    int packets_seen;
    int packets_converted;
    int packets_passed;
    int bank_expansions;

    function new();
      mismatches = 0;
      results_checked = 0;
      packets_seen = 0;
      packets_converted = 0;
      packets_passed = 0;
      bank_expansions = 0;
    endfunction

    function int pending();
      return midi1_due.size();
    endfunction

    function logic [31:0] cv1_word(logic [3:0] grp, logic [3:0] op, logic [3:0] ch,
                                   logic [6:0] d1, logic [6:0] d2);
      return {MT_CV1, grp, op, ch, 1'b0, d1, 1'b0, d2};
    endfunction

    function void due_converted(logic [31:0] word, logic [TS_W-1:0] ts, logic fin);
      out_pkt_t r;
      r = '{word, 32'd0, 32'd0, 32'd0, NW_MIN, ts, fin};
      midi1_due.push_back(r);
    endfunction

    // Translate one accepted packet into the results it must cause
    function void note_packet(in_pkt_t p);
      logic [3:0]      grp;
      logic [3:0]      st;
      logic [3:0]      ch;
      logic [6:0]      idx;
      logic [31:0]     w1;
      logic [2:0]      n;
      logic [TS_W-1:0] ts;
      out_pkt_t        pass;
      logic            converted;

      packets_seen++;
      grp = p.in_word0[27:24];
      st  = p.in_word0[23:20];
      ch  = p.in_word0[19:16];
      idx = p.in_word0[14:8];
      w1  = p.in_word1;
      ts  = p.in_timestamp;
      n   = p.in_num_words;
      if (n == 3'd0) n = NW_MIN;
      else if (n > NW_MAX) n = NW_MAX;
      pass = '{p.in_word0, p.in_word1, p.in_word2, p.in_word3, n, ts, 1'b1};

      converted = 1'b0;
      if (p.in_word0[31:28] == MT_CV2) begin
        converted = 1'b1;
        case (st)
          ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRESS, ST_CTRL: begin
            due_converted(cv1_word(grp, st, ch, idx, w1[31:25]), ts, 1'b1);
          end
          ST_CHAN_PRESS: begin
            due_converted(cv1_word(grp, st, ch, w1[31:25], 7'd0), ts, 1'b1);
          end
          ST_BEND: begin
            // 14-bit bend from the top of the word, LSB first
            due_converted(cv1_word(grp, st, ch, w1[24:18], w1[31:25]), ts, 1'b1);
          end
          ST_PROGRAM: begin
            if (p.in_word0[0]) begin
              bank_expansions++;
              due_converted(cv1_word(grp, ST_CTRL, ch, CC_BANK_MSB, w1[14:8]), ts, 1'b0);
              due_converted(cv1_word(grp, ST_CTRL, ch, CC_BANK_LSB, w1[6:0]),
                            ts + 1'b1, 1'b0);
            end
            // program change always lands two ticks on, bank or not
            due_converted(cv1_word(grp, ST_PROGRAM, ch, w1[30:24], 7'd0),
                          ts + 2'd2, 1'b1);
          end
          default: begin
            converted = 1'b0;
          end
        endcase
      end

      if (converted) begin
        packets_converted++;
      end else begin
        packets_passed++;
        midi1_due.push_back(pass);
      end
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH result %0d %s: expected %h, got %h",
                 results_checked, what, want, got);
    endfunction

    function void check_result(out_pkt_t got);
      out_pkt_t want;

      if (midi1_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH unexpected result: word0 %h ts %h last %b",
                   got.out_word0, got.out_timestamp, got.last);
        return;
      end
      want = midi1_due.pop_front();
      if (got.out_word0 !== want.out_word0) flag("word0", want.out_word0, got.out_word0);
      if (got.out_word1 !== want.out_word1) flag("word1", want.out_word1, got.out_word1);
      if (got.out_word2 !== want.out_word2) flag("word2", want.out_word2, got.out_word2);
      if (got.out_word3 !== want.out_word3) flag("word3", want.out_word3, got.out_word3);
      if (got.out_num_words !== want.out_num_words)
        flag("num_words", want.out_num_words, got.out_num_words);
      if (got.out_timestamp !== want.out_timestamp)
        flag("timestamp", want.out_timestamp, got.out_timestamp);
      if (got.last !== want.last) flag("last", want.last, got.last);
      results_checked++;
    endfunction
  endclass

endpackage

[tb/sv/ump_midi2_to_midi1_downscaler_tb.sv]
// ----------------------------------------------------------------------------
// ump_midi2_to_midi1_downscaler_tb
// Drives directed and random UMP packets into the downscaler under varying
// sender and receiver stalls, and checks every result in order against a
// translation done in the testbench.
// ----------------------------------------------------------------------------
module ump_midi2_to_midi1_downscaler_tb;
  import umpds_pkg::*;
  import umpds_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PACKETS = 108;
  localparam logic [TS_W-1:0] TS_TOP = '1;

  logic     clk = 1'b0;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  in_pkt_t  in_data;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_pkt_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;

  midi1_scoreboard sb = new();

  ump_midi2_to_midi1_downscaler dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // note inputs before checking outputs; the block's latency keeps them apart
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_packet(in_data);
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, sb.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic in_pkt_t pkt(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                                   logic [31:0] w3, logic [2:0] n, logic [TS_W-1:0] ts);
    return '{w0, w1, w2, w3, n, ts};
  endfunction

  function automatic logic [31:0] cv2_head(logic [3:0] grp, logic [3:0] st,
                                           logic [3:0] ch, logic [7:0] idx,
                                           logic [7:0] low);
    return {MT_CV2, grp, st, ch, idx, low};
  endfunction

  function automatic in_pkt_t random_packet();
    logic [3:0]  ops [7];
    logic [31:0] w0;
    logic [2:0]  n;
    logic [63:0] t;
    int          pick;

    ops = '{ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRESS, ST_CTRL,
            ST_PROGRAM, ST_CHAN_PRESS, ST_BEND};
    pick = $urandom_range(99);
    w0 = $urandom;
    if (pick < 75) begin
      // well-formed channel voice, with extra weight on program change
      w0[31:28] = MT_CV2;
      w0[23:20] = (pick < 20) ? ST_PROGRAM : ops[$urandom_range(6)];
    end else if (pick < 82) begin
      w0[31:28] = MT_CV2;
    end
    n = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
    t = {$urandom, $urandom};
    if ($urandom_range(9) == 0) t[TS_W-1:0] = TS_TOP - TS_W'($urandom_range(3));
    return pkt(w0, $urandom, $urandom, $urandom, n, t[TS_W-1:0]);
  endfunction

  task automatic send_packet(in_pkt_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  // Lower valid and hold off until every due result has come back
  task automatic hold_off();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  initial begin
    int phase;
    int i;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 83;

    // passthrough: other types, odd lengths, extreme words and timestamps
    send_packet(pkt(32'h2090_3C40, 32'h0, 32'h0, 32'h0, 3'd1, '0));
    send_packet(pkt('1, '1, '1, '1, 3'd4, TS_TOP));
    send_packet(pkt(32'h0000_0000, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 3'd0, 63'd5));
    send_packet(pkt(32'h5F00_0000, '1, '1, '1, 3'd7, 63'd6));
    send_packet(pkt(32'h3A00_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A, '1, 3'd5, 63'd7));
    // each channel voice status but program change, data at both ends
    send_packet(pkt(cv2_head(4'hF, ST_NOTE_OFF, 4'hF, 8'hFF, 8'hFF), '1, '1, '1, 3'd2, TS_TOP));
    send_packet(pkt(cv2_head(4'h0, ST_NOTE_ON, 4'h0, 8'h3C, 8'h00), '0, '0, '0, 3'd2, 63'd1));
    send_packet(pkt(cv2_head(4'h3, ST_NOTE_ON, 4'h9, 8'h7F, 8'h00), 32'hFFFF_0000, '0, '0,
                    3'd2, 63'd2));
    send_packet(pkt(cv2_head(4'h1, ST_POLY_PRESS, 4'h2, 8'h80, 8'h00), '1, '0, '0, 3'd2, 63'd3));
    send_packet(pkt(cv2_head(4'h2, ST_CTRL, 4'h5, 8'h7F, 8'h00), 32'h8000_0000, '0, '0,
                    3'd2, 63'd4));
    send_packet(pkt(cv2_head(4'h4, ST_CHAN_PRESS, 4'hA, 8'hFF, 8'hFF), '1, '0, '0, 3'd2, 63'd8));
    send_packet(pkt(cv2_head(4'h5, ST_BEND, 4'h3, 8'h00, 8'h00), '1, '0, '0, 3'd2, 63'd9));
    send_packet(pkt(cv2_head(4'h6, ST_BEND, 4'hC, 8'h00, 8'h00), 32'h8000_0000, '0, '0,
                    3'd2, 63'd10));
    // program change with and without bank, timestamps wrapping at the top
    send_packet(pkt(cv2_head(4'h7, ST_PROGRAM, 4'h1, 8'hFF, 8'hFE), '1, '1, '1, 3'd2, TS_TOP));
    send_packet(pkt(cv2_head(4'h8, ST_PROGRAM, 4'h4, 8'h00, 8'h01), '1, '0, '0, 3'd2, TS_TOP));
    send_packet(pkt(cv2_head(4'h9, ST_PROGRAM, 4'h7, 8'h00, 8'h01), '0, '0, '0, 3'd2,
                    TS_TOP - 1'b1));
    send_packet(pkt(cv2_head(4'hA, ST_PROGRAM, 4'hE, 8'h00, 8'hFF), 32'h7F00_7F7F, '0, '0,
                    3'd2, 63'd11));
    // channel voice statuses that are not translated
    send_packet(pkt(cv2_head(4'hB, 4'h0, 4'h6, 8'h11, 8'h22), '1, 32'h1, 32'h2, 3'd2, 63'd12));
    send_packet(pkt('1 & 32'h4FFF_FFFF, '1, '1, '1, 3'd4, 63'd13));
    send_packet(pkt(cv2_head(4'hC, 4'h7, 4'h8, 8'h33, 8'h44), 32'h5555_AAAA, 32'h3, 32'h4,
                    3'd3, 63'd14));
    // short and over-long channel voice packets still convert
    send_packet(pkt(cv2_head(4'hD, ST_NOTE_ON, 4'hB, 8'h40, 8'h00), 32'hC000_0000, '1, '1,
                    3'd1, 63'd15));
    send_packet(pkt(cv2_head(4'hE, ST_CTRL, 4'hD, 8'h07, 8'h00), 32'hFE00_0000, '1, '1,
                    3'd0, 63'd16));
    send_packet(pkt(cv2_head(4'hF, ST_PROGRAM, 4'hF, 8'h00, 8'h01), 32'h5A12_3456, '1, '1,
                    3'd7, 63'd17));
    hold_off();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 83;
        end
        1: begin
          send_idle_pct = 83;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (i = 0; i < RANDOM_PACKETS / 3 + 1; i++) begin
        send_packet(random_packet());
        if (phase == 2 && i == 20) hold_off();
      end
      hold_off();
    end

    repeat (16) @(posedge clk);
    if (sb.pending() != 0) sb.mismatches += sb.pending();

    $display("Checked %0d results from %0d packets: %0d translated, %0d passed through",
             sb.results_checked, sb.packets_seen, sb.packets_converted, sb.packets_passed);
    $display("%0d program changes carried bank selects; %0d mismatches counted",
             sb.bank_expansions, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/umpds_pkg.sv
hw/rtl/umpds_expand.sv
hw/rtl/ump_midi2_to_midi1_downscaler.sv
tb/sv/umpds_scoreboard_pkg.sv
tb/sv/ump_midi2_to_midi1_downscaler_tb.sv
